### rtl/core/mwcs_pkg.sv
// ----------------------------------------------------------------------------
// mwcs_pkg
// shared constants, codes and types of the shortest covering window search
// ----------------------------------------------------------------------------
package mwcs_pkg;

    // queue of needed text characters
    localparam int QUEUE_DEPTH = 1024;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // text positions
    localparam int MAX_TEXT = 65536;
    localparam int QPOS_W   = $clog2(MAX_TEXT);
    localparam int POS_W    = $clog2(MAX_TEXT + 1);

    // alphabet
    localparam int         ALPHABET    = 58;
    localparam int         LETTER_W    = $clog2(ALPHABET);
    localparam int         NLET_W      = $clog2(ALPHABET + 1);
    localparam logic [7:0] LETTER_BASE = 8'h41;

    // per-letter counts
    localparam int                  COUNT_W   = 11;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

    // queue entry: letter in the high bits, position in the low bits
    localparam int QENT_W = LETTER_W + QPOS_W;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // result field widths
    localparam int START_W = 16;
    localparam int LEN_W   = 17;

    // item kinds
    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_PATTERN = 2'd1;
    localparam logic [1:0] KIND_TEXT    = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic                letter_ok;
        logic [LETTER_W-1:0] letter;
    } cmd_t;

    typedef struct packed {
        logic               overflow;
        logic [LEN_W-1:0]   length;
        logic [START_W-1:0] start_res;
        logic               found;
    } result_t;

endpackage

### rtl/core/min_window_cover_search.sv
// ----------------------------------------------------------------------------
// min_window_cover_search
// shortest text window that holds every pattern letter, with multiplicity
// ----------------------------------------------------------------------------
// Each input beat carries a kind in s_tuser and a character byte in s_tdata:
// clear, pattern character, text character or end of text. Letters are the
// codes 'A' and up over the alphabet; other bytes are ignored (a text byte
// still takes a position). Pattern characters count only before any text.
// An end beat returns one result beat with found, start, length and an
// overflow flag (queue full, a count stuck at its maximum, or text too long).
// A four-entry command queue parts the front decoder from the search engine,
// so beats are taken while the engine works. In the engine, clear, end and
// a non-letter text byte are handled in the idle state, a pattern letter
// also passes ST_PAT, a needed text letter ST_TXT and ST_CHK, and each window
// pop runs ST_CHK (queue ram read), ST_PRL (count ram read) and ST_PUPD
// (update); every queued letter is popped at most once. The count tables hold
// per-entry valid bits, so clear takes effect at once with no clearing pass.
module min_window_cover_search
    import mwcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] start_res, [32:16] length, zero above
    output logic [1:0]  m_tuser    // [0] found, [1] overflow
);

    cmd_t    cmd;
    logic    cmd_valid, cmd_ready;
    result_t res;
    logic    res_valid, res_ready;

    // output register
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;

    mwcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mwcs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result slot frees up when empty or when the current beat is taken
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_res_reg.length, m_res_reg.start_res};
    assign m_tuser  = {m_res_reg.overflow, m_res_reg.found};

endmodule

### rtl/core/mwcs_ram.sv
// ----------------------------------------------------------------------------
// mwcs_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mwcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/mwcs_front.sv
// ----------------------------------------------------------------------------
// mwcs_front
// accepts input beats, decodes letters, queues commands for the back end
// ----------------------------------------------------------------------------
module mwcs_front
    import mwcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    cmd_t                  fifo_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wptr_reg, wptr_next;
    logic [CMDQ_PTR_W-1:0] rptr_reg, rptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  push, pop;
    cmd_t                  new_cmd;
    logic [7:0]            offset;

    // letter decode
    always_comb begin
        offset            = s_tdata - LETTER_BASE;
        new_cmd.kind      = s_tuser;
        new_cmd.letter_ok = (s_tdata >= LETTER_BASE) && ({1'b0, offset} < 9'(ALPHABET));
        new_cmd.letter    = offset[LETTER_W-1:0];
    end

    assign s_tready  = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = fifo_reg[rptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (push) begin
            wptr_next = (wptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                  : wptr_reg + CMDQ_PTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                  : rptr_reg + CMDQ_PTR_W'(1);
        end
        cnt_next = cnt_reg + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            fifo_reg[wptr_reg] <= new_cmd;
        end
    end

endmodule

### rtl/core/mwcs_back.sv
// ----------------------------------------------------------------------------
// mwcs_back
// search engine: letter counts, position queue, window pops, best window
// ----------------------------------------------------------------------------
module mwcs_back
    import mwcs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAT  = 3'd1;
    localparam logic [2:0] ST_TXT  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_PRL  = 3'd4;
    localparam logic [2:0] ST_PUPD = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [POS_W-1:0]    tp_reg, tp_next;
    logic [POS_W-1:0]    cur_pos_reg, cur_pos_next;
    logic [LETTER_W-1:0] cur_letter_reg, cur_letter_next;
    logic [NLET_W-1:0]   needed_reg, needed_next;
    logic [NLET_W-1:0]   sat_reg, sat_next;
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QPTR_W-1:0]   tail_reg, tail_next;
    logic [QCNT_W-1:0]   used_reg, used_next;
    logic [QPOS_W-1:0]   best_start_reg, best_start_next;
    logic [POS_W-1:0]    best_len_reg, best_len_next;
    logic                best_found_reg, best_found_next;
    logic                ovf_reg, ovf_next;
    logic [ALPHABET-1:0] req_vld_reg, req_vld_next;
    logic [ALPHABET-1:0] win_vld_reg, win_vld_next;
    logic                req_vq_reg, req_vq_next;
    logic                win_vq_reg, win_vq_next;

    // ram ports
    logic                cnt_re;
    logic [LETTER_W-1:0] cnt_raddr;
    logic                req_we, win_we;
    logic [COUNT_W-1:0]  req_wdata, win_wdata;
    logic [COUNT_W-1:0]  req_q, win_q;
    logic                q_we, q_re;
    logic [QENT_W-1:0]   q_wdata, q_rdata;

    logic [COUNT_W-1:0]  req_val, win_val;
    logic [LETTER_W-1:0] q_letter;
    logic [QPOS_W-1:0]   q_pos;
    logic [POS_W-1:0]    win_len;
    logic                pop_cond;

    assign req_val  = req_vq_reg ? req_q : '0;
    assign win_val  = win_vq_reg ? win_q : '0;
    assign q_letter = q_rdata[QENT_W-1 -: LETTER_W];
    assign q_pos    = q_rdata[QPOS_W-1:0];
    assign win_len  = cur_pos_reg - POS_W'(q_pos) + POS_W'(1);
    assign pop_cond = (needed_reg != '0) && (sat_reg == needed_reg) && (used_reg != '0);

    assign cnt_raddr = (state_reg == ST_IDLE) ? cmd.letter : q_letter;
    assign q_wdata   = {cur_letter_reg, cur_pos_reg[QPOS_W-1:0]};

    assign res.found     = best_found_reg;
    assign res.start_res = best_found_reg ? START_W'(best_start_reg) : '0;
    assign res.length    = best_found_reg ? LEN_W'(best_len_reg) : '0;
    assign res.overflow  = ovf_reg;

    always_comb begin
        state_next      = state_reg;
        tp_next         = tp_reg;
        cur_pos_next    = cur_pos_reg;
        cur_letter_next = cur_letter_reg;
        needed_next     = needed_reg;
        sat_next        = sat_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        used_next       = used_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        best_found_next = best_found_reg;
        ovf_next        = ovf_reg;
        req_vld_next    = req_vld_reg;
        win_vld_next    = win_vld_reg;
        req_vq_next     = req_vq_reg;
        win_vq_next     = win_vq_reg;
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;
        cnt_re          = 1'b0;
        req_we          = 1'b0;
        win_we          = 1'b0;
        req_wdata       = req_val + COUNT_W'(1);
        win_wdata       = win_val + COUNT_W'(1);
        q_we            = 1'b0;
        q_re            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready = 1'b1;
                    unique case (cmd.kind)
                        KIND_CLEAR: begin
                            tp_next         = '0;
                            needed_next     = '0;
                            sat_next        = '0;
                            head_next       = '0;
                            tail_next       = '0;
                            used_next       = '0;
                            best_start_next = '0;
                            best_len_next   = '0;
                            best_found_next = 1'b0;
                            ovf_next        = 1'b0;
                            req_vld_next    = '0;
                            win_vld_next    = '0;
                        end
                        KIND_PATTERN: begin
                            if (cmd.letter_ok && tp_reg == '0) begin
                                cnt_re          = 1'b1;
                                req_vq_next     = req_vld_reg[cmd.letter];
                                cur_letter_next = cmd.letter;
                                state_next      = ST_PAT;
                            end
                        end
                        KIND_TEXT: begin
                            if (tp_reg >= POS_W'(MAX_TEXT)) begin
                                ovf_next = 1'b1;
                            end else begin
                                cur_pos_next = tp_reg;
                                tp_next      = tp_reg + POS_W'(1);
                                if (cmd.letter_ok) begin
                                    cnt_re          = 1'b1;
                                    req_vq_next     = req_vld_reg[cmd.letter];
                                    win_vq_next     = win_vld_reg[cmd.letter];
                                    cur_letter_next = cmd.letter;
                                    state_next      = ST_TXT;
                                end
                            end
                        end
                        KIND_END: begin
                            res_valid = 1'b1;
                            cmd_ready = res_ready;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PAT: begin
                if (req_val == '0) begin
                    needed_next = needed_reg + NLET_W'(1);
                end
                if (req_val >= COUNT_MAX) begin
                    ovf_next = 1'b1;
                end else begin
                    req_we                       = 1'b1;
                    req_vld_next[cur_letter_reg] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_TXT: begin
                state_next = ST_IDLE;
                if (req_val != '0) begin
                    if (used_reg >= QCNT_W'(QUEUE_DEPTH)) begin
                        ovf_next = 1'b1;
                    end else begin
                        q_we      = 1'b1;
                        tail_next = (tail_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                           : tail_reg + QPTR_W'(1);
                        used_next = used_reg + QCNT_W'(1);
                        if (win_val >= COUNT_MAX) begin
                            ovf_next = 1'b1;
                        end else begin
                            win_we                       = 1'b1;
                            win_vld_next[cur_letter_reg] = 1'b1;
                            if (win_val + COUNT_W'(1) == req_val) begin
                                sat_next = sat_reg + NLET_W'(1);
                            end
                        end
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                if (pop_cond) begin
                    q_re       = 1'b1;
                    state_next = ST_PRL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRL: begin
                cnt_re          = 1'b1;
                req_vq_next     = req_vld_reg[q_letter];
                win_vq_next     = win_vld_reg[q_letter];
                cur_letter_next = q_letter;
                state_next      = ST_PUPD;
            end
            ST_PUPD: begin
                if (!best_found_reg || win_len < best_len_reg) begin
                    best_found_next = 1'b1;
                    best_len_next   = win_len;
                    best_start_next = q_pos;
                end
                head_next = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QPTR_W'(1);
                used_next = used_reg - QCNT_W'(1);
                if (win_val != '0) begin
                    if (win_val == req_val && sat_reg != '0) begin
                        sat_next = sat_reg - NLET_W'(1);
                    end
                    win_we    = 1'b1;
                    win_wdata = win_val - COUNT_W'(1);
                end
                state_next = ST_CHK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tp_reg         <= '0;
            needed_reg     <= '0;
            sat_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            used_reg       <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            best_found_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            req_vld_reg    <= '0;
            win_vld_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            tp_reg         <= tp_next;
            needed_reg     <= needed_next;
            sat_reg        <= sat_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            used_reg       <= used_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            best_found_reg <= best_found_next;
            ovf_reg        <= ovf_next;
            req_vld_reg    <= req_vld_next;
            win_vld_reg    <= win_vld_next;
        end
        cur_pos_reg    <= cur_pos_next;
        cur_letter_reg <= cur_letter_next;
        req_vq_reg     <= req_vq_next;
        win_vq_reg     <= win_vq_next;
    end

    mwcs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (ALPHABET)
    ) u_req_ram (
        .aclk  (aclk),
        .we    (req_we),
        .waddr (cur_letter_reg),
        .wdata (req_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (req_q)
    );

    mwcs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (ALPHABET)
    ) u_win_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (cur_letter_reg),
        .wdata (win_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (win_q)
    );

    mwcs_ram #(
        .WIDTH (QENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

endmodule
